// ===== design/htlp_pkg.sv =====
// Shared types and constants for the linear-probe hash table core.
// Used by htlp_mod, htlp_ram users and hash_table_linear_probe_core.
`timescale 1ns / 1ps
`default_nettype none

package htlp_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int KEY_BYTES_DEF = 8;

  // table_size register: 7 bits, so at most 127 slots are ever in use
  localparam int SIZE_W   = 7;
  localparam int MAX_SIZE = 127;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // APB port
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [31:0]       found_value;
    logic [SIZE_W-1:0] occupied;
  } rsp_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_res_t;

endpackage

`default_nettype wire

// ===== design/hash_table_linear_probe_core.sv =====
// Open-addressed hash table with linear probing. Keys (up to KEY_BYTES bytes,
// cut at the first zero byte) and values live in one RAM; occupancy is a row
// of flip-flops cleared at once by reset, a clear request or a write of
// table_size (which also empties the table). One request is worked at a time.
// Count and clear skip hashing and probing. Set and get first form the home
// slot with a bit-serial remainder unit over the SUM_W-bit key sum (11 bits
// for 8-byte keys), then probe one slot per cycle, visiting up to the
// effective table size. The result register lets the next request enter
// while a response waits.
// Depends on htlp_pkg, htlp_mod and htlp_ram.
`timescale 1ns / 1ps
`default_nettype none

module hash_table_linear_probe_core #(
  parameter int SLOTS     = htlp_pkg::SLOTS_DEF,
  parameter int KEY_BYTES = htlp_pkg::KEY_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [htlp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [htlp_pkg::APB_W-1:0]  pwdata,
  output logic      [htlp_pkg::APB_W-1:0]  prdata,
  output logic                             pready,
  // request channel
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire htlp_pkg::req_t              req,
  // response channel
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output htlp_pkg::rsp_t                   rsp
);

  import htlp_pkg::*;

  localparam int USED   = (SLOTS < MAX_SIZE) ? SLOTS : MAX_SIZE;
  localparam int IDX_W  = (USED > 1) ? $clog2(USED) : 1;
  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int DATA_W = KEY_W + 32;
  localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HASH  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] count;
  logic [USED-1:0]   used;

  cmd_t              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [31:0]       val_q;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  cur_wrap;
  logic [SIZE_W-1:0] cur_inc;
  logic [SIZE_W-1:0] left;
  logic              chk_vld;
  rsp_t              res;

  logic              cfg_wr;
  logic              req_fire;
  logic              rsp_free;
  logic [KEY_W-1:0]  key_form;
  logic [SUM_W-1:0]  key_sum;
  logic              alive;
  logic [7:0]        kbyte;

  logic              mod_start;
  mod_res_t          mres;

  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  logic              key_match;
  logic              set_store;
  logic              set_full;
  logic              get_hit;
  logic              get_miss;
  logic              probe_end;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_TABLE_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_TABLE_SIZE) begin
      prdata = APB_W'(table_size);
    end
  end

  always_comb begin
    if (table_size == '0) begin
      size = SIZE_W'(1);
    end else if (table_size > SIZE_W'(USED)) begin
      size = SIZE_W'(USED);
    end else begin
      size = table_size;
    end
  end

  // ---------------- request intake ----------------
  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid & ~req_stall;
  assign rsp_free  = ~rsp_valid | ~rsp_stall;

  // cut the key at its first zero byte, and sum its bytes
  always_comb begin
    alive    = 1'b1;
    key_form = '0;
    key_sum  = '0;
    kbyte    = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      kbyte = req.key[8*i +: 8];
      if (kbyte == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_form[8*i +: 8] = kbyte;
        key_sum            = key_sum + SUM_W'(kbyte);
      end
    end
  end

  assign mod_start = req_fire & ((req.command == CMD_SET) || (req.command == CMD_GET));

  htlp_mod #(
    .SUM_W (SUM_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key_sum),
    .divisor  (size),
    .res      (mres)
  );

  // ---------------- probe ----------------
  // Set probes occupancy flops only and writes the RAM; get reads the RAM one
  // slot per cycle and checks the slot read in the previous cycle. The two
  // never overlap, so no forwarding is needed.
  htlp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (USED)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata ({key_q, val_q}),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_inc   = SIZE_W'(cur) + SIZE_W'(1);
    cur_wrap  = (cur_inc == size) ? '0 : IDX_W'(cur_inc);
    key_match = (ram_rdata[DATA_W-1 -: KEY_W] == key_q);
    set_store = (state == ST_PROBE) && (cmd_q == CMD_SET) && !used[cur];
    set_full  = (state == ST_PROBE) && (cmd_q == CMD_SET) && used[cur]
                && (left == SIZE_W'(1));
    get_hit   = (state == ST_PROBE) && (cmd_q == CMD_GET) && chk_vld
                && used[cur_q] && key_match;
    get_miss  = (state == ST_PROBE) && (cmd_q == CMD_GET) && chk_vld
                && (!used[cur_q] || (!key_match && (left == SIZE_W'(1))));
    probe_end = set_store | set_full | get_hit | get_miss;
    ram_we    = set_store;
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chk_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if ((req.command == CMD_SET) || (req.command == CMD_GET)) begin
              state <= ST_HASH;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_HASH: begin
          chk_vld <= 1'b0;
          if (mres.done) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (cmd_q == CMD_GET) begin
            chk_vld <= 1'b1;
          end
          if (probe_end) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request payload, probe pointers and pending result
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q           <= req.command;
      key_q           <= key_form;
      val_q           <= req.value;
      res.ok          <= 1'b0;
      res.found_value <= '0;
      res.occupied    <= (req.command == CMD_CLEAR) ? '0 : count;
    end
    if ((state == ST_HASH) && mres.done) begin
      cur  <= IDX_W'(mres.rem);
      left <= size;
    end
    if (state == ST_PROBE) begin
      cur_q <= cur;
      if (probe_end) begin
        res.ok          <= set_store | get_hit;
        res.found_value <= get_hit ? ram_rdata[31:0] : '0;
        res.occupied    <= set_store ? count + SIZE_W'(1) : count;
      end else begin
        cur <= cur_wrap;
        if ((cmd_q == CMD_SET) || chk_vld) begin
          left <= left - SIZE_W'(1);
        end
      end
    end
  end

  // table state: occupancy, fill count, size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
      used       <= '0;
      count      <= '0;
    end else if (cfg_wr) begin
      table_size <= pwdata[SIZE_W-1:0];
      used       <= '0;
      count      <= '0;
    end else if (req_fire && (req.command == CMD_CLEAR)) begin
      used  <= '0;
      count <= '0;
    end else if (set_store) begin
      used[cur] <= 1'b1;
      count     <= count + SIZE_W'(1);
    end
  end

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && rsp_free) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("fill count differs from occupied slot flags");

  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (SIZE_W'(cur) < size))
    else $error("probe pointer outside the table");

  a_probe_budget: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (left != '0))
    else $error("probe ran past its slot budget");

  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (count == $past(count) + SIZE_W'(1)))
    else $error("store did not bump the fill count");
`endif

endmodule

`default_nettype wire

// ===== design/htlp_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/htlp_mod.sv =====
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on htlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htlp_mod #(
  parameter int SUM_W = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [SUM_W-1:0]            dividend,
  input  wire logic [htlp_pkg::SIZE_W-1:0] divisor,
  output htlp_pkg::mod_res_t               res
);

  import htlp_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] quo;
  logic [SIZE_W-1:0] rmd;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic [SIZE_W-1:0] rmd_next;

  // remainder stays below the divisor, so the shifted value fits SIZE_W+1 bits
  always_comb begin
    shifted  = {rmd, quo[SUM_W-1]};
    diff     = shifted - {1'b0, dvs};
    rmd_next = (shifted >= {1'b0, dvs}) ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rmd <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo << 1;
      rmd <= rmd_next;
    end
  end

  assign res.done = done;
  assign res.rem  = rmd;

endmodule

`default_nettype wire

// ===== sim/hash_table_linear_probe_core_tb.sv =====
// Self-checking testbench for hash_table_linear_probe_core: directed and random
// set/get/count/clear requests over several table sizes, checked against a
// table model kept in a small scoreboard class. Depends on htlp_pkg.
`timescale 1ns / 1ps

module hash_table_linear_probe_core_tb;
  import htlp_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 83;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall;
  rsp_t              rsp;

  int          send_idle_pct = 0;
  int          rsp_stall_pct = 0;
  int          items_sent    = 0;
  int unsigned cycle_cnt     = 0;
  logic [63:0] key_pool[$];

  // Linear-probe table model plus the queue of responses it predicts.
  class probe_table;
    bit              used[SLOTS];
    logic [63:0]     slot_key[SLOTS];
    logic [31:0]     slot_val[SLOTS];
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;
    int unsigned     n_used = 0;
    int              errors = 0;
    rsp_t            expected_rsp[$];

    function void wipe();
      for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
      n_used = 0;
    endfunction

    function void resize(logic [SIZE_W-1:0] sz);
      size_reg = sz;
      wipe();
    endfunction

    function int unsigned eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > SLOTS) return SLOTS;
      return size_reg;
    endfunction

    // Drop everything from the first zero byte on.
    function logic [63:0] cut_key(logic [63:0] raw);
      logic [63:0] k;
      k = '0;
      for (int i = 0; i < KEY_BYTES_DEF; i++) begin
        if (raw[8*i +: 8] == 8'h00) break;
        k[8*i +: 8] = raw[8*i +: 8];
      end
      return k;
    endfunction

    function int unsigned home_of(logic [63:0] k, int unsigned sz);
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < 8; i++) sum += k[8*i +: 8];
      return sum % sz;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      logic [63:0] k;
      int unsigned sz;
      int unsigned cur;
      sz  = eff_size();
      k   = cut_key(r.key);
      cur = home_of(k, sz);
      e   = '0;
      case (r.command)
        CMD_SET: begin
          for (int n = 0; n < sz; n++) begin
            if (!used[cur]) begin
              used[cur]     = 1'b1;
              slot_key[cur] = k;
              slot_val[cur] = r.value;
              n_used++;
              e.ok = 1'b1;
              break;
            end
            cur = (cur + 1 == sz) ? 0 : cur + 1;
          end
        end
        CMD_GET: begin
          for (int n = 0; n < sz; n++) begin
            if (!used[cur]) break;
            if (slot_key[cur] == k) begin
              e.ok          = 1'b1;
              e.found_value = slot_val[cur];
              break;
            end
            cur = (cur + 1 == sz) ? 0 : cur + 1;
          end
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
      e.occupied = SIZE_W'(n_used);
      expected_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response ok=%0b found_value=%h occupied=%0d",
                 $time, got.ok, got.found_value, got.occupied);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (got.ok !== e.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, e.ok, got.ok);
        errors++;
      end
      if (got.found_value !== e.found_value) begin
        $display("%0t: found_value expected %h actual %h", $time, e.found_value,
                 got.found_value);
        errors++;
      end
      if (got.occupied !== e.occupied) begin
        $display("%0t: occupied expected %0d actual %0d", $time, e.occupied,
                 got.occupied);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  probe_table table_model = new();

  hash_table_linear_probe_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("hash_table_linear_probe_core_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) table_model.check_response(rsp);
  end

  // Random key of 0..8 nonzero bytes, sometimes with junk past the terminator.
  function automatic logic [63:0] make_key();
    logic [63:0] k;
    int          len;
    k   = '0;
    len = $urandom_range(8, 0);
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(255, 1));
    if (len < 7 && $urandom_range(3) == 0) begin
      for (int i = len + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
    end
    return k;
  endfunction

  task automatic send(input cmd_t c, input logic [63:0] k, input logic [31:0] v);
    req_t r;
    r.command = c;
    r.key     = k;
    r.value   = v;
    if (items_sent < 280) begin
      send_idle_pct = 29;
      rsp_stall_pct = 66;
    end else if (items_sent < 560) begin
      send_idle_pct = 66;
      rsp_stall_pct = 29;
    end else begin
      send_idle_pct = 0;
      rsp_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    table_model.note_request(r);
    items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (table_model.pending() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input int unsigned sz);
    logic [APB_W-1:0] data;
    drain();
    repeat (4) @(posedge clk);
    data = ($urandom & ~32'h7F) | (sz & 32'h7F);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_TABLE_SIZE);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    table_model.resize(data[SIZE_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(input int n, input bit pause_midway);
    int          pick;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      pick = $urandom_range(99);
      if (pick < 42) begin
        if (key_pool.size() > 0 && $urandom_range(4) == 0) begin
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
          k = make_key();
          key_pool.push_back(k);
          if (key_pool.size() > 32) void'(key_pool.pop_front());
        end
        send(CMD_SET, k, $urandom);
      end else if (pick < 84) begin
        if (key_pool.size() > 0 && $urandom_range(4) != 0)
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
          k = make_key();
        send(CMD_GET, k, $urandom);
      end else if (pick < 95) begin
        send(CMD_COUNT, {$urandom, $urandom}, $urandom);
      end else begin
        send(CMD_CLEAR, {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  initial begin
    int unsigned sizes[10];
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset size
    send(CMD_COUNT, 64'h0, 32'h0);
    send(CMD_GET, 64'h41, 32'h0);
    send(CMD_SET, 64'h0, 32'h1234_5678);
    send(CMD_GET, 64'hFFFF_FFFF_FFFF_FF00, 32'h0);   // empty key, junk after it
    send(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send(CMD_SET, 64'h00AA_0000_0000_0041, 32'hA5A5_0001);
    send(CMD_GET, 64'h41, 32'h0);
    send(CMD_SET, 64'h41, 32'h5A5A_0002);            // duplicate key
    send(CMD_GET, 64'h0000_7700_0000_0041, 32'h0);
    send(CMD_SET, 64'h0201, 32'h0000_0201);
    send(CMD_SET, 64'h0102, 32'h0000_0102);          // same home slot
    send(CMD_GET, 64'h0102, 32'h0);
    send(CMD_GET, 64'h03, 32'h0);                    // miss along a probe chain
    send(CMD_SET, 64'h8080_8080_8080_8080, 32'h8080_8080);
    send(CMD_GET, 64'h8080_8080_8080_8080, 32'h0);
    send(CMD_GET, 64'h0, 32'h0);
    send(CMD_CLEAR, 64'hDEAD_BEEF_0000_0001, 32'hFFFF_FFFF);
    send(CMD_GET, 64'h41, 32'h0);
    send(CMD_COUNT, 64'h0, 32'h0);

    sizes = '{1, 0, 127, 7, 2, 65, 33, 64,
              $urandom_range(64, 1), $urandom_range(16, 3)};
    foreach (sizes[p]) begin
      write_table_size(sizes[p]);
      run_random(PHASE_ITEMS, p == 3);
    end

    drain();
    repeat (20) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending() == 0) begin
      $display("hash_table_linear_probe_core_tb passed");
    end else begin
      $display("hash_table_linear_probe_core_tb failed");
    end
    $finish;
  end

endmodule
